// ===== design/poid_pkg.sv =====
// shared types, constants and helpers for the per object identifier decoder
`timescale 1ns / 1ps

package poid_pkg;

  localparam int ARC_WIDTH  = 32;
  localparam int ARC_OUT_W  = 32;
  localparam int CLEN_W     = 14;
  localparam int LENHI_W    = 6;
  localparam int CONS_W     = 15;
  localparam logic [CONS_W-1:0] CONS_MAX = '1;
  localparam logic [7:0] FIRST_ARC_DIV = 8'd40;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN2,
    PH_FIRST,
    PH_ARCS
  } phase_t;

  typedef enum logic [0:0] {
    ERR_NONE     = 1'b0,
    ERR_HUGE_LEN = 1'b1
  } err_t;

  typedef struct packed {
    logic [ARC_OUT_W-1:0] arc_value;
    logic                 arc_valid;
    logic                 is_last;
    err_t                 error_code;
  } result_t;

  // byte / 40 as (byte >> 3) / 5, the latter by multiply 13 and shift 6
  function automatic logic [2:0] div40(input logic [7:0] b);
    logic [9:0] prod;
    prod = {5'd0, b[7:3]} * 10'd13;
    return prod[8:6];
  endfunction

  function automatic logic [5:0] mod40(input logic [7:0] b, input logic [2:0] q);
    logic [7:0] qx;
    qx = {5'd0, q} * FIRST_ARC_DIV;
    return 6'(b - qx);
  endfunction

endpackage

// ===== design/poid_dec.sv =====
// byte decoder: length determinant and arc accumulation state machine
`timescale 1ns / 1ps

module poid_dec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        data_byte,
  output logic [1:0]        res_cnt,
  output poid_pkg::result_t res0,
  output poid_pkg::result_t res1
);

  poid_pkg::phase_t                  phase_r, phase_nxt;
  logic [poid_pkg::CLEN_W-1:0]       clen_r, clen_nxt;
  logic [poid_pkg::LENHI_W-1:0]      lenhi_r, lenhi_nxt;
  logic [poid_pkg::CONS_W-1:0]       cons_r, cons_nxt;
  logic [poid_pkg::ARC_WIDTH-1:0]    acc_r, acc_nxt;

  logic [poid_pkg::CLEN_W-1:0]       len_in;
  logic                              len_now;
  logic [poid_pkg::CONS_W-1:0]       cons_inc;
  logic [poid_pkg::ARC_WIDTH-1:0]    acc_new;
  logic [2:0]                        q40;
  logic                              last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= poid_pkg::PH_IDLE;
      clen_r  <= '0;
      lenhi_r <= '0;
      cons_r  <= '0;
      acc_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      clen_r  <= clen_nxt;
      lenhi_r <= lenhi_nxt;
      cons_r  <= cons_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    clen_nxt  = clen_r;
    lenhi_nxt = lenhi_r;
    cons_nxt  = cons_r;
    acc_nxt   = acc_r;
    res_cnt   = 2'd0;
    res0      = '0;
    res1      = '0;
    len_in    = '0;
    len_now   = 1'b0;
    last      = 1'b0;
    q40       = poid_pkg::div40(data_byte);
    cons_inc  = (cons_r == poid_pkg::CONS_MAX) ? cons_r : cons_r + 1'b1;
    acc_new   = {acc_r[poid_pkg::ARC_WIDTH-8:0], data_byte[6:0]};

    unique case (phase_r)
      poid_pkg::PH_IDLE: begin
        if (!data_byte[7]) begin
          len_in  = {7'd0, data_byte[6:0]};
          len_now = 1'b1;
        end else if (!data_byte[6]) begin
          lenhi_nxt = data_byte[5:0];
          phase_nxt = poid_pkg::PH_LEN2;
        end else begin
          res_cnt         = 2'd1;
          res0.is_last    = 1'b1;
          res0.error_code = poid_pkg::ERR_HUGE_LEN;
          phase_nxt       = poid_pkg::PH_IDLE;
        end
      end
      poid_pkg::PH_LEN2: begin
        len_in  = {lenhi_r, data_byte};
        len_now = 1'b1;
      end
      poid_pkg::PH_FIRST: begin
        cons_nxt       = {{(poid_pkg::CONS_W-1){1'b0}}, 1'b1};
        last           = (clen_r <= poid_pkg::CLEN_W'(1));
        res_cnt        = 2'd2;
        res0.arc_value = poid_pkg::ARC_OUT_W'(q40);
        res0.arc_valid = 1'b1;
        res1.arc_value = poid_pkg::ARC_OUT_W'(poid_pkg::mod40(data_byte, q40));
        res1.arc_valid = 1'b1;
        res1.is_last   = last;
        acc_nxt        = '0;
        phase_nxt      = last ? poid_pkg::PH_IDLE : poid_pkg::PH_ARCS;
      end
      poid_pkg::PH_ARCS: begin
        cons_nxt = cons_inc;
        if (data_byte[7]) begin
          acc_nxt = acc_new;
        end else begin
          acc_nxt        = '0;
          last           = (cons_inc >= {1'b0, clen_r});
          res_cnt        = 2'd1;
          res0.arc_value = poid_pkg::ARC_OUT_W'(acc_new);
          res0.arc_valid = 1'b1;
          res0.is_last   = last;
          if (last) begin
            phase_nxt = poid_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = poid_pkg::PH_IDLE;
      end
    endcase

    // length known: empty identifier ends here, otherwise go to content
    if (len_now) begin
      clen_nxt = len_in;
      cons_nxt = '0;
      acc_nxt  = '0;
      if (len_in == '0) begin
        res_cnt      = 2'd1;
        res0.is_last = 1'b1;
        phase_nxt    = poid_pkg::PH_IDLE;
      end else begin
        phase_nxt = poid_pkg::PH_FIRST;
      end
    end
  end

`ifndef ASSERT_OFF
  a_err_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_cnt != 2'd0 && res0.error_code == poid_pkg::ERR_HUGE_LEN)
      |-> (res0.is_last && !res0.arc_valid && res_cnt == 2'd1))
    else $error("error result not a lone final item");
  a_len2_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (take && phase_r == poid_pkg::PH_LEN2) |=> (phase_r != poid_pkg::PH_LEN2))
    else $error("second length byte did not leave length phase");
  a_first_after_len: assert property (@(posedge clk) disable iff (!rst_n)
    (take && phase_r == poid_pkg::PH_FIRST) |-> (clen_r != '0))
    else $error("content phase entered with zero length");
`endif

endmodule

// ===== design/poid_rq.sv =====
// four-entry result queue taking up to two results per cycle
`timescale 1ns / 1ps

module poid_rq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  poid_pkg::result_t push0,
  input  poid_pkg::result_t push1,
  input  logic              pop,
  output logic              has_room,
  output logic              head_valid,
  output poid_pkg::result_t head
);

  poid_pkg::result_t mem_r [4];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] wr_p1;
  logic [2:0] count_r, count_nxt;

  always_comb begin
    wr_p1     = wr_r + 2'd1;
    wr_nxt    = wr_r + push_cnt;
    rd_nxt    = rd_r + {1'b0, pop};
    count_nxt = count_r + {1'b0, push_cnt} - {2'b00, pop};
  end

  // room for a pair whatever the decoder pushes next
  assign has_room   = (count_r <= 3'd2);
  assign head_valid = (count_r != 3'd0);
  assign head       = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_p1] <= push1;
    end
  end

`ifndef ASSERT_OFF
  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> (count_r <= 3'd2))
    else $error("result queue push without room");
  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != 3'd0))
    else $error("result queue pop while empty");
  a_pair_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt == 2'd2) |=> (count_r >= 3'd2 || $past(pop)))
    else $error("result pair lost");
`endif

endmodule

// ===== design/per_object_identifier_decoder_core.sv =====
// top level of the per object identifier decoder
`timescale 1ns / 1ps

// usage
// - input stream: one byte of an encoded object identifier per item, length
//   determinant first, then the content bytes; the next identifier follows
//   directly after the last content byte
// - result stream: one arc per item on out_tdata; out_tlast marks the final
//   result of an identifier; out_tuser carries arc_valid and error_code
// - an empty identifier or an unsupported long length gives one item with
//   arc_valid low and out_tlast high
// - the results of an accepted byte are registered in the result queue and
//   reach the output from its head, after any results already waiting
// - one byte per cycle while the result queue has room; the first content
//   byte gives two arcs, so the output side takes two items for it
// - a four-entry result queue sits between decoder and output; a byte is
//   taken while the queue holds at most two results, so a stalled receiver
//   backs up the input once three or four results are pending
// - reset: rst_n low clears the decoder to wait for a length byte and
//   empties the result queue

module per_object_identifier_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] arc_value
  output logic [1:0]  out_tuser,  // [0] arc_valid, [1] error_code
  output logic        out_tlast   // is_last
);

  logic              take;
  logic              room;
  logic [1:0]        res_cnt;
  logic [1:0]        push_cnt;
  poid_pkg::result_t res0, res1, head;

  assign in_tready = room;
  assign take      = in_tvalid && room;
  assign push_cnt  = take ? res_cnt : 2'd0;

  // byte decoding and identifier state
  poid_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_tdata),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  // results wait here for the receiver
  poid_rq u_rq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push0      (res0),
    .push1      (res1),
    .pop        (out_tvalid && out_tready),
    .has_room   (room),
    .head_valid (out_tvalid),
    .head       (head)
  );

  assign out_tdata = head.arc_value;
  assign out_tuser = {head.error_code, head.arc_valid};
  assign out_tlast = head.is_last;

`ifndef ASSERT_OFF
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_cnt != 2'd0) |=> out_tvalid)
    else $error("accepted byte produced no visible result");
  a_err_no_arc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (!out_tuser[0] && out_tlast))
    else $error("error item carries an arc");
`endif

endmodule
